// ===== src/gasm_pkg.sv =====
// Package for the grid authentication sequence monitor.
// Holds the request and result types, the command and direction codes and
// the handshake stage encoding. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gasm_pkg;

  // Default counter width for the frame counter and the histogram.
  localparam int COUNT_WIDTH_DEF = 32;

  // Histogram geometry: one entry per command byte value.
  localparam int CMD_W      = 8;
  localparam int HIST_DEPTH = 1 << CMD_W;

  // Reset value of the repeat limit register.
  localparam logic [7:0] REPEAT_LIMIT_RST = 8'd3;

  // Direction codes.
  localparam logic [2:0] DIR_MASTER   = 3'd1;
  localparam logic [2:0] DIR_TERMINAL = 3'd3;

  // Control byte that carries the authentication handshake.
  localparam logic [7:0] CTRL_AUTH = 8'h80;

  // Command codes.
  localparam logic [7:0] CMD_AUTH_REQ  = 8'h20;
  localparam logic [7:0] CMD_AUTH_CHAL = 8'h21;
  localparam logic [7:0] CMD_AUTH_RESP = 8'h22;
  localparam logic [7:0] CMD_AUTH_ACK  = 8'h23;
  localparam logic [7:0] CMD_REQ_50    = 8'h50;
  localparam logic [7:0] CMD_RPL_51    = 8'h51;
  localparam logic [7:0] CMD_REQ_52    = 8'h52;
  localparam logic [7:0] CMD_RPL_53    = 8'h53;
  localparam logic [7:0] CMD_REQ_54    = 8'h54;
  localparam logic [7:0] CMD_RPL_55    = 8'h55;
  localparam logic [7:0] CMD_REPEAT    = 8'h56;
  localparam logic [7:0] CMD_REQ_60    = 8'h60;
  localparam logic [7:0] CMD_RPL_61    = 8'h61;

  // Codes of the pair that a frame closes.
  localparam logic [2:0] PAIR_NONE = 3'd0;
  localparam logic [2:0] PAIR_5051 = 3'd1;
  localparam logic [2:0] PAIR_5253 = 3'd2;
  localparam logic [2:0] PAIR_5455 = 3'd3;
  localparam logic [2:0] PAIR_6061 = 3'd4;

  // Authentication handshake stage.
  typedef enum logic [2:0] {
    STG_NONE  = 3'd0,
    STG_GOT20 = 3'd1,
    STG_GOT21 = 3'd2,
    STG_GOT22 = 3'd3,
    STG_DONE  = 3'd4
  } auth_stage_t;

  // One decoded frame summary.
  typedef struct packed {
    logic       frame_valid;
    logic [2:0] direction;
    logic [7:0] control_byte;
    logic [7:0] command_byte;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [2:0]  auth_stage;
    logic        auth_done;
    logic        auth_first_done;
    logic        pair_5051_seen;
    logic        pair_5253_seen;
    logic        pair_5455_seen;
    logic        pair_6061_seen;
    logic [2:0]  pair_closed;
    logic        repeat_warning;
    logic [31:0] frame_total;
    logic [31:0] command_total;
  } out_item_t;

  // Status from the sequence tracker to the top level.
  typedef struct packed {
    logic [2:0]  auth_stage;
    logic        auth_done;
    logic        auth_first_done;
    logic [3:0]  seen;
    logic [2:0]  pair_closed;
    logic        repeat_warning;
    logic [31:0] frame_total;
  } seq_status_t;

endpackage

`default_nettype wire

// ===== src/gasm_hist.sv =====
// Per-command histogram memory with read-modify-write and forwarding.
// Uses gasm_pkg for the histogram geometry.
`timescale 1ns / 1ps
`default_nettype none

module gasm_hist #(
  parameter int COUNT_WIDTH = gasm_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [gasm_pkg::CMD_W-1:0]   rd_addr,
  input  wire logic                         wb_en,
  output logic      [COUNT_WIDTH-1:0]       cur_count,
  output logic      [COUNT_WIDTH-1:0]       inc_count
);
  import gasm_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0]  ent_vld_r;
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic                   rd_vld_r;
  logic [CMD_W-1:0]       addr_r;
  logic                   byp_vld_r;
  logic [CMD_W-1:0]       byp_addr_r;
  logic [COUNT_WIDTH-1:0] byp_data_r;

  // Memory array: synchronous read on request accept, write-back of the increment.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      addr_r    <= rd_addr;
    end
    if (wb_en) begin
      mem[addr_r] <= inc_count;
      byp_addr_r  <= addr_r;
      byp_data_r  <= inc_count;
    end
  end

  // Entry valid bits stand in for clearing the memory at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      byp_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= ent_vld_r[rd_addr];
      end
      if (wb_en) begin
        ent_vld_r[addr_r] <= 1'b1;
        byp_vld_r         <= 1'b1;
      end
    end
  end

  // The last write-back may have landed after the read was taken, so it wins on a match.
  always_comb begin
    if (byp_vld_r && (byp_addr_r == addr_r)) begin
      cur_count = byp_data_r;
    end else if (rd_vld_r) begin
      cur_count = rd_data_r;
    end else begin
      cur_count = '0;
    end
  end

  // Saturating increment.
  assign inc_count = (cur_count == {COUNT_WIDTH{1'b1}}) ? cur_count
                                                         : cur_count + 1'b1;

endmodule

`default_nettype wire

// ===== src/gasm_seq.sv =====
// Sequence tracker: handshake stage, request/reply pairing, repeat count,
// frame counter and the repeat limit register. Uses gasm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gasm_seq #(
  parameter int COUNT_WIDTH = gasm_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [7:0]            cfg_wr_data,
  input  wire logic                  step_en,
  input  wire gasm_pkg::in_item_t    item,
  output gasm_pkg::seq_status_t      status
);
  import gasm_pkg::*;

  auth_stage_t            stage_r, stage_nxt;
  logic                   done_r, done_nxt;
  logic [3:0]             waiting_r, waiting_nxt;
  logic [3:0]             seen_r, seen_nxt;
  logic [7:0]             repeat_cnt_r, repeat_cnt_nxt;
  logic [COUNT_WIDTH-1:0] frame_cnt_r, frame_cnt_nxt;
  logic [7:0]             limit_r;
  logic                   first_done;
  logic [2:0]             closed;
  logic                   is_master;
  logic                   is_terminal;
  logic                   auth_ctl;
  logic [3:0]             req_hit;
  logic [3:0]             rpl_hit;
  logic [3:0]             close_hit;
  logic [63:0]            frame_ext;

  assign is_master   = item.frame_valid && (item.direction == DIR_MASTER);
  assign is_terminal = item.frame_valid && (item.direction == DIR_TERMINAL);
  assign auth_ctl    = item.frame_valid && (item.control_byte == CTRL_AUTH);

  // Handshake stage: next state.
  always_comb begin
    stage_nxt = stage_r;
    if (auth_ctl) begin
      if (is_master && (item.command_byte == CMD_AUTH_REQ)) begin
        stage_nxt = STG_GOT20;
      end else if (is_terminal && (item.command_byte == CMD_AUTH_CHAL) &&
                   (stage_r == STG_GOT20)) begin
        stage_nxt = STG_GOT21;
      end else if (is_master && (item.command_byte == CMD_AUTH_RESP) &&
                   (stage_r == STG_GOT21)) begin
        stage_nxt = STG_GOT22;
      end else if (is_terminal && (item.command_byte == CMD_AUTH_ACK) &&
                   (stage_r == STG_GOT22)) begin
        stage_nxt = STG_DONE;
      end
    end
  end

  // Handshake outputs: completion flag and its first-time pulse.
  always_comb begin
    first_done = (stage_nxt == STG_DONE) && (stage_r != STG_DONE) && !done_r;
    done_nxt   = done_r || ((stage_nxt == STG_DONE) && (stage_r != STG_DONE));
  end

  // Decode of the request and reply commands of the four pairs.
  always_comb begin
    req_hit = 4'b0000;
    rpl_hit = 4'b0000;
    case (item.command_byte)
      CMD_REQ_50: req_hit[0] = 1'b1;
      CMD_REQ_52: req_hit[1] = 1'b1;
      CMD_REQ_54: req_hit[2] = 1'b1;
      CMD_REQ_60: req_hit[3] = 1'b1;
      CMD_RPL_51: rpl_hit[0] = 1'b1;
      CMD_RPL_53: rpl_hit[1] = 1'b1;
      CMD_RPL_55: rpl_hit[2] = 1'b1;
      CMD_RPL_61: rpl_hit[3] = 1'b1;
      default: begin
        req_hit = 4'b0000;
        rpl_hit = 4'b0000;
      end
    endcase
  end

  // A reply closes a pair only while its request is waiting.
  assign close_hit   = is_terminal ? (rpl_hit & waiting_r) : 4'b0000;
  assign waiting_nxt = is_master ? (waiting_r | req_hit) : (waiting_r & ~close_hit);
  assign seen_nxt    = seen_r | close_hit;

  always_comb begin
    case (close_hit)
      4'b0001: closed = PAIR_5051;
      4'b0010: closed = PAIR_5253;
      4'b0100: closed = PAIR_5455;
      4'b1000: closed = PAIR_6061;
      default: closed = PAIR_NONE;
    endcase
  end

  // Saturating counters.
  always_comb begin
    repeat_cnt_nxt = repeat_cnt_r;
    if (is_master && (item.command_byte == CMD_REPEAT) && (repeat_cnt_r != 8'hFF)) begin
      repeat_cnt_nxt = repeat_cnt_r + 8'd1;
    end
    frame_cnt_nxt = frame_cnt_r;
    if (item.frame_valid && (frame_cnt_r != {COUNT_WIDTH{1'b1}})) begin
      frame_cnt_nxt = frame_cnt_r + 1'b1;
    end
  end

  // State registers advance only when the request leaves for the output stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r      <= STG_NONE;
      done_r       <= 1'b0;
      waiting_r    <= 4'b0000;
      seen_r       <= 4'b0000;
      repeat_cnt_r <= 8'd0;
      frame_cnt_r  <= '0;
    end else if (step_en) begin
      stage_r      <= stage_nxt;
      done_r       <= done_nxt;
      waiting_r    <= waiting_nxt;
      seen_r       <= seen_nxt;
      repeat_cnt_r <= repeat_cnt_nxt;
      frame_cnt_r  <= frame_cnt_nxt;
    end
  end

  // Repeat limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= REPEAT_LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Result fields reflect the state after this request.
  assign frame_ext = 64'(frame_cnt_nxt);

  always_comb begin
    status.auth_stage      = stage_nxt;
    status.auth_done       = done_nxt;
    status.auth_first_done = first_done;
    status.seen            = seen_nxt;
    status.pair_closed     = closed;
    status.repeat_warning  = (repeat_cnt_nxt >= limit_r) && !seen_nxt[0];
    status.frame_total     = frame_ext[31:0];
  end

endmodule

`default_nettype wire

// ===== src/grid_auth_sequence_monitor.sv =====
// Top level of the grid authentication sequence monitor.
// Instantiates gasm_hist and gasm_seq; uses gasm_pkg.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one decoded frame
//   summary per request. Output channel out_valid / out_stall / out_data
//   returns exactly one result per request, in order.
//   cfg_wr_en / cfg_wr_data write the repeat limit; write it only while idle.
//   An accepted request passes the read stage and then the output register.
//   Throughput: one request per cycle while the receiver does not stall, also
//   when consecutive requests carry the same command; the histogram
//   read-modify-write forwards the last write-back into the next update.
//   The histogram memory has one read and one write port; its 256 entries
//   are cleared at reset through one valid bit per entry, so no clearing
//   pass is needed and requests are taken right after reset.
//   When the receiver stalls, the result holds in the output register and
//   one more request is taken into the read stage before in_stall rises.
//   Reset (rst_n low, synchronous) empties both stages and clears all
//   flags, counters and histogram entries; the repeat limit returns to 3.
`timescale 1ns / 1ps
`default_nettype none

module grid_auth_sequence_monitor #(
  parameter int COUNT_WIDTH = gasm_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire gasm_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gasm_pkg::out_item_t     out_data
);
  import gasm_pkg::*;

  logic                   in_acc;
  logic                   s1_adv;
  logic                   s1_vld_r, s1_vld_nxt;
  in_item_t               s1_item_r;
  logic                   out_vld_r, out_vld_nxt;
  out_item_t              out_data_r, out_data_nxt;
  logic [COUNT_WIDTH-1:0] cur_count;
  logic [COUNT_WIDTH-1:0] inc_count;
  logic [COUNT_WIDTH-1:0] cmd_count;
  logic [63:0]            cmd_ext;
  seq_status_t            status;

  // Handshake: the read stage moves on when the output register is free.
  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign s1_vld_nxt  = in_acc || (s1_vld_r && !s1_adv);
  assign out_vld_nxt = s1_adv || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Read stage holds the request while its histogram entry is fetched.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  gasm_hist #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_addr   (in_data.command_byte),
    .wb_en     (s1_adv && s1_item_r.frame_valid),
    .cur_count (cur_count),
    .inc_count (inc_count)
  );

  gasm_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (s1_adv),
    .item        (s1_item_r),
    .status      (status)
  );

  // Assemble the result; an invalid frame reports the unchanged entry.
  assign cmd_count = s1_item_r.frame_valid ? inc_count : cur_count;
  assign cmd_ext   = 64'(cmd_count);

  always_comb begin
    out_data_nxt.auth_stage      = status.auth_stage;
    out_data_nxt.auth_done       = status.auth_done;
    out_data_nxt.auth_first_done = status.auth_first_done;
    out_data_nxt.pair_5051_seen  = status.seen[0];
    out_data_nxt.pair_5253_seen  = status.seen[1];
    out_data_nxt.pair_5455_seen  = status.seen[2];
    out_data_nxt.pair_6061_seen  = status.seen[3];
    out_data_nxt.pair_closed     = status.pair_closed;
    out_data_nxt.repeat_warning  = status.repeat_warning;
    out_data_nxt.frame_total     = status.frame_total;
    out_data_nxt.command_total   = cmd_ext[31:0];
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== src/gasm_checker.sv =====
// Port-level checker for the grid authentication sequence monitor, bound to
// the top level. Uses gasm_pkg for the payload types and codes.
`timescale 1ns / 1ps
`default_nettype none

module gasm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                cfg_wr_en,
  input wire logic [7:0]          cfg_wr_data,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire gasm_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire gasm_pkg::out_item_t out_data
);
  import gasm_pkg::*;

  // A stalled result must stay put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The output stage is empty in the cycle after a reset edge.
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // The first-completion pulse only comes with a completed handshake.
  a_first_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.auth_first_done |->
      out_data.auth_done && (out_data.auth_stage == STG_DONE))
    else $error("first completion without completed handshake");

  // A closed pair is already reported as seen in the same result.
  a_pair_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_data.pair_closed != PAIR_5051) || out_data.pair_5051_seen) &&
      ((out_data.pair_closed != PAIR_5253) || out_data.pair_5253_seen) &&
      ((out_data.pair_closed != PAIR_5455) || out_data.pair_5455_seen) &&
      ((out_data.pair_closed != PAIR_6061) || out_data.pair_6061_seen))
    else $error("closed pair not flagged as seen");

  // The repeat warning is masked once the 50/51 pair has been seen.
  a_warn_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.repeat_warning |-> !out_data.pair_5051_seen)
    else $error("repeat warning despite 50/51 pair");

endmodule

bind grid_auth_sequence_monitor gasm_checker u_gasm_checker (.*);

`default_nettype wire

// ===== verif/gasm_result_checker.sv =====
// Result checker for the grid authentication sequence monitor.
// Watches the request, result and register ports, predicts every result and
// compares it field by field. Uses the types and codes of gasm_pkg.
`timescale 1ns / 1ps

module gasm_result_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  gasm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  gasm_pkg::out_item_t out_data,
  output int                  fail_count
);
  import gasm_pkg::*;

  // Predicted state of the monitor.
  logic [7:0]  warn_limit;
  auth_stage_t stage;
  logic        handshake_done;
  logic [3:0]  awaiting_reply;
  logic [3:0]  pairs_closed;
  logic [7:0]  repeat_frames;
  logic [31:0] frames_counted;
  logic [31:0] cmd_hist [HIST_DEPTH];

  out_item_t expected_results[$];
  int        errors = 0;

  function automatic logic [31:0] sat_up(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // Applies one request to the predicted state and returns its result.
  task automatic predict_frame(input in_item_t f, output out_item_t r);
    logic [2:0] closed;
    logic       first_done;
    int         slot;
    closed     = PAIR_NONE;
    first_done = 1'b0;
    if (f.frame_valid) begin
      frames_counted = sat_up(frames_counted);
      cmd_hist[f.command_byte] = sat_up(cmd_hist[f.command_byte]);
      if (f.direction == DIR_MASTER && f.command_byte == CMD_REPEAT && repeat_frames != 8'hFF)
        repeat_frames = repeat_frames + 8'd1;

      // Handshake: a master 0x20 restarts it from any stage.
      if (f.control_byte == CTRL_AUTH) begin
        if (f.direction == DIR_MASTER && f.command_byte == CMD_AUTH_REQ) begin
          stage = STG_GOT20;
        end else if (f.direction == DIR_TERMINAL && f.command_byte == CMD_AUTH_CHAL &&
                     stage == STG_GOT20) begin
          stage = STG_GOT21;
        end else if (f.direction == DIR_MASTER && f.command_byte == CMD_AUTH_RESP &&
                     stage == STG_GOT21) begin
          stage = STG_GOT22;
        end else if (f.direction == DIR_TERMINAL && f.command_byte == CMD_AUTH_ACK &&
                     stage == STG_GOT22) begin
          stage          = STG_DONE;
          first_done     = !handshake_done;
          handshake_done = 1'b1;
        end
      end

      // Request and reply pairing.
      slot = -1;
      if (f.direction == DIR_MASTER) begin
        case (f.command_byte)
          CMD_REQ_50: slot = 0;
          CMD_REQ_52: slot = 1;
          CMD_REQ_54: slot = 2;
          CMD_REQ_60: slot = 3;
          default: slot = -1;
        endcase
        if (slot >= 0)
          awaiting_reply[slot] = 1'b1;
      end else if (f.direction == DIR_TERMINAL) begin
        case (f.command_byte)
          CMD_RPL_51: slot = 0;
          CMD_RPL_53: slot = 1;
          CMD_RPL_55: slot = 2;
          CMD_RPL_61: slot = 3;
          default: slot = -1;
        endcase
        if (slot >= 0 && awaiting_reply[slot]) begin
          awaiting_reply[slot] = 1'b0;
          pairs_closed[slot]   = 1'b1;
          closed               = PAIR_5051 + 3'(slot);
        end
      end
    end

    r.auth_stage      = stage;
    r.auth_done       = handshake_done;
    r.auth_first_done = first_done;
    r.pair_5051_seen  = pairs_closed[0];
    r.pair_5253_seen  = pairs_closed[1];
    r.pair_5455_seen  = pairs_closed[2];
    r.pair_6061_seen  = pairs_closed[3];
    r.pair_closed     = closed;
    // The warning level follows the present limit on every request.
    r.repeat_warning  = (repeat_frames >= warn_limit) && !pairs_closed[0];
    r.frame_total     = frames_counted;
    r.command_total   = cmd_hist[f.command_byte];
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Everything is sampled at the rising edge, before the block's outputs move.
  always @(posedge clk) begin
    out_item_t pred;
    if (!rst_n) begin
      warn_limit     = REPEAT_LIMIT_RST;
      stage          = STG_NONE;
      handshake_done = 1'b0;
      awaiting_reply = '0;
      pairs_closed   = '0;
      repeat_frames  = '0;
      frames_counted = '0;
      for (int i = 0; i < HIST_DEPTH; i++)
        cmd_hist[i] = '0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en)
        warn_limit = cfg_wr_data;
      if (in_valid && !in_stall) begin
        predict_frame(in_data, pred);
        expected_results.push_back(pred);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result without a pending request, expected none, actual %h",
                   $time, out_data);
        end else begin
          pred = expected_results.pop_front();
          check_field("auth_stage", pred.auth_stage, out_data.auth_stage);
          check_field("auth_done", pred.auth_done, out_data.auth_done);
          check_field("auth_first_done", pred.auth_first_done, out_data.auth_first_done);
          check_field("pair_5051_seen", pred.pair_5051_seen, out_data.pair_5051_seen);
          check_field("pair_5253_seen", pred.pair_5253_seen, out_data.pair_5253_seen);
          check_field("pair_5455_seen", pred.pair_5455_seen, out_data.pair_5455_seen);
          check_field("pair_6061_seen", pred.pair_6061_seen, out_data.pair_6061_seen);
          check_field("pair_closed", pred.pair_closed, out_data.pair_closed);
          check_field("repeat_warning", pred.repeat_warning, out_data.repeat_warning);
          check_field("frame_total", pred.frame_total, out_data.frame_total);
          check_field("command_total", pred.command_total, out_data.command_total);
        end
      end
    end
    // Results still owed count as failures too.
    fail_count <= errors + expected_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the testbench for the grid authentication sequence monitor.
// Drives requests, result stalls and the repeat limit; gasm_result_checker
// predicts and compares. Needs gasm_pkg and grid_auth_sequence_monitor.
`timescale 1ns / 1ps

module testbench;
  import gasm_pkg::*;

  // Direction codes that the package leaves unnamed.
  localparam logic [2:0] DIR_UNKNOWN     = 3'd0;
  localparam logic [2:0] DIR_TO_TERMINAL = 3'd2;
  localparam logic [2:0] DIR_TO_MASTER   = 3'd4;
  localparam logic [2:0] DIR_RESERVED_LO = 3'd5;
  localparam logic [2:0] DIR_RESERVED_HI = 3'd7;

  localparam int RESET_CYCLES    = 9;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int TIMEOUT_NS      = 5_000_000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;

  // Progress of the two channels and the idle-free stretches.
  int       frames_sent   = 0;
  int       results_taken = 0;
  int       tx_run        = 0;
  int       rx_run        = 0;
  bit       hold_off_req  = 1'b0;
  in_item_t frame_plan[$];

  always #5 clk = ~clk;

  grid_auth_sequence_monitor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  gasm_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count)
  );

  function automatic in_item_t frame(logic v, logic [2:0] d, logic [7:0] c, logic [7:0] m);
    in_item_t f;
    f.frame_valid  = v;
    f.direction    = d;
    f.control_byte = c;
    f.command_byte = m;
    return f;
  endfunction

  function automatic in_item_t noise_frame();
    return frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                 8'($urandom), 8'($urandom));
  endfunction

  // Queues one short sequence: a 0x56 burst, a handshake, a request with its
  // reply, or plain noise. p56 is the percentage of 0x56 bursts.
  task automatic plan_frames(int p56);
    int         pick;
    int         n;
    int         bad;
    logic [7:0] ctrl;
    logic [7:0] req;
    in_item_t   f;
    pick = $urandom_range(0, 99);
    if (pick < p56) begin
      n = $urandom_range(1, 8);
      repeat (n) frame_plan.push_back(frame(1'b1, DIR_MASTER, 8'($urandom), CMD_REPEAT));
    end else if (pick < p56 + 25) begin
      // Handshake, sometimes cut short or with one frame damaged.
      n   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 4;
      bad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : -1;
      for (int k = 0; k < n; k++) begin
        f = frame(1'b1, (k % 2 == 0) ? DIR_MASTER : DIR_TERMINAL, CTRL_AUTH,
                  CMD_AUTH_REQ + 8'(k));
        if (k == bad) begin
          case ($urandom_range(0, 2))
            0: f.control_byte = 8'($urandom);
            1: f.direction = 3'($urandom_range(0, 7));
            default: f.command_byte = f.command_byte ^ 8'(1 << $urandom_range(0, 7));
          endcase
        end
        frame_plan.push_back(f);
      end
    end else if (pick < p56 + 55) begin
      ctrl = 8'($urandom);
      case ($urandom_range(0, 3))
        0: req = CMD_REQ_50;
        1: req = CMD_REQ_52;
        2: req = CMD_REQ_54;
        default: req = CMD_REQ_60;
      endcase
      frame_plan.push_back(frame(1'b1, DIR_MASTER, ctrl, req));
      if ($urandom_range(0, 3) == 0)
        frame_plan.push_back(frame(1'b1, DIR_MASTER, ctrl, req));
      n = $urandom_range(0, 2);
      repeat (n) frame_plan.push_back(noise_frame());
      // Each reply code is its request code plus one.
      frame_plan.push_back(frame(1'b1, ($urandom_range(0, 7) == 0) ? DIR_TO_MASTER : DIR_TERMINAL,
                                 ctrl, req + 8'd1));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) frame_plan.push_back(noise_frame());
    end
  endtask

  // Offers one request and returns once it is taken, at the falling edge.
  task automatic send_frame(in_item_t f);
    int gap;
    if (tx_run > 0) begin
      gap = 0;
      tx_run--;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 39) == 0)
        tx_run = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall);
    frames_sent++;
    @(negedge clk);
  endtask

  // Random requests. While the 50/51 pair must stay open, terminal 0x51
  // replies are turned around so that the warning stays reachable.
  task automatic send_random(int count, int p56, bit allow_5051);
    in_item_t f;
    repeat (count) begin
      if (frame_plan.size() == 0)
        plan_frames(p56);
      f = frame_plan.pop_front();
      if ($urandom_range(0, 49) == 0)
        f.frame_valid = 1'b0;
      if (!allow_5051 && f.frame_valid && f.direction == DIR_TERMINAL &&
          f.command_byte == CMD_RPL_51)
        f.direction = DIR_TO_MASTER;
      send_frame(f);
    end
  endtask

  task automatic wait_idle();
    while (results_taken < frames_sent) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // The limit is only written once every result is out.
  task automatic write_limit(logic [7:0] value);
    in_valid <= 1'b0;
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: a random stall before each result, runs without stalls,
  // and one long hold-off on request.
  initial begin
    int hold;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold         = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else if (rx_run > 0) begin
        hold = 0;
        rx_run--;
      end else begin
        hold = $urandom_range(0, 16);
        if ($urandom_range(0, 39) == 0)
          rx_run = $urandom_range(10, 60);
      end
      out_stall <= (hold > 0);
      if (hold > 0) begin
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      results_taken++;
      @(negedge clk);
    end
  end

  // Main sequence of phases.
  initial begin
    in_item_t opening[$];
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset limit of three.
    opening.push_back(frame(1'b0, DIR_MASTER, CTRL_AUTH, CMD_AUTH_REQ));
    opening.push_back(frame(1'b0, DIR_RESERVED_HI, 8'hFF, 8'hFF));
    opening.push_back(frame(1'b1, DIR_TERMINAL, CTRL_AUTH, CMD_AUTH_CHAL));
    opening.push_back(frame(1'b1, DIR_MASTER, CTRL_AUTH, CMD_AUTH_REQ));
    opening.push_back(frame(1'b1, DIR_MASTER, 8'h00, CMD_AUTH_RESP));
    opening.push_back(frame(1'b1, DIR_TERMINAL, CTRL_AUTH, CMD_AUTH_CHAL));
    opening.push_back(frame(1'b1, DIR_MASTER, CTRL_AUTH, CMD_AUTH_RESP));
    opening.push_back(frame(1'b1, DIR_TERMINAL, CTRL_AUTH, CMD_AUTH_ACK));
    // A new 0x20 restarts a completed handshake, which then completes again.
    opening.push_back(frame(1'b1, DIR_MASTER, CTRL_AUTH, CMD_AUTH_REQ));
    opening.push_back(frame(1'b1, DIR_TERMINAL, CTRL_AUTH, CMD_AUTH_CHAL));
    opening.push_back(frame(1'b1, DIR_MASTER, CTRL_AUTH, CMD_AUTH_RESP));
    opening.push_back(frame(1'b1, DIR_TERMINAL, CTRL_AUTH, CMD_AUTH_ACK));
    opening.push_back(frame(1'b1, DIR_RESERVED_LO, CTRL_AUTH, CMD_AUTH_REQ));
    opening.push_back(frame(1'b1, DIR_RESERVED_HI, 8'hFF, CMD_REQ_52));
    opening.push_back(frame(1'b1, DIR_TERMINAL, 8'h00, CMD_RPL_53));
    opening.push_back(frame(1'b1, DIR_MASTER, 8'h00, CMD_REQ_52));
    opening.push_back(frame(1'b1, DIR_MASTER, 8'h00, CMD_REQ_52));
    opening.push_back(frame(1'b1, DIR_TERMINAL, 8'h00, CMD_RPL_53));
    opening.push_back(frame(1'b1, DIR_MASTER, 8'hFF, CMD_REQ_54));
    opening.push_back(frame(1'b1, DIR_TO_TERMINAL, 8'hFF, CMD_RPL_55));
    opening.push_back(frame(1'b1, DIR_TERMINAL, 8'hFF, CMD_RPL_55));
    opening.push_back(frame(1'b1, DIR_MASTER, 8'h00, CMD_REQ_60));
    opening.push_back(frame(1'b1, DIR_TERMINAL, 8'h00, CMD_RPL_61));
    repeat (3) opening.push_back(frame(1'b1, DIR_MASTER, 8'h00, CMD_REPEAT));
    opening.push_back(frame(1'b1, DIR_TERMINAL, 8'h00, CMD_RPL_51));
    opening.push_back(frame(1'b1, DIR_UNKNOWN, 8'h00, 8'h00));
    foreach (opening[i]) send_frame(opening[i]);

    write_limit(8'd1);
    send_random(250, 10, 1'b0);

    // Highest limit; 0x56 bursts dominate so the count saturates here.
    // It opens with a long result hold-off while requests keep coming.
    write_limit(8'hFF);
    hold_off_req = 1'b1;
    tx_run       = HOLD_OFF_CYCLES;
    send_random(500, 40, 1'b0);

    // A zero limit raises the warning as long as 50/51 stays open.
    write_limit(8'd0);
    send_random(150, 15, 1'b0);

    // Close the 50/51 pair, which drops the warning for good.
    write_limit(8'($urandom_range(2, 254)));
    send_frame(frame(1'b1, DIR_MASTER, 8'h00, CMD_REQ_50));
    send_frame(frame(1'b1, DIR_TERMINAL, 8'h00, CMD_RPL_51));
    send_frame(frame(1'b1, DIR_MASTER, 8'h00, CMD_REPEAT));
    send_random(280, 15, 1'b1);

    write_limit(8'($urandom_range(1, 255)));
    send_random(250, 15, 1'b1);

    in_valid <= 1'b0;
    wait_idle();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #TIMEOUT_NS;
    $display("Regression FAIL");
    $finish;
  end

endmodule
